// File: rtl/core/vdi_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and helpers for the vertex dedup indexer.
// No dependencies; the core files refer to it by scoped names, the test files import it.
package vdi_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int COMP_W      = 24;
  localparam int TOL_W       = 23;
  localparam int VIDX_W      = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W       = (COMP_W + 1 > TOL_W) ? COMP_W + 1 : TOL_W;

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(41);

  typedef struct packed {
    logic signed [COMP_W-1:0] pos_x;
    logic signed [COMP_W-1:0] pos_y;
    logic signed [COMP_W-1:0] pos_z;
    logic signed [COMP_W-1:0] col_r;
    logic signed [COMP_W-1:0] col_g;
    logic signed [COMP_W-1:0] col_b;
  } vertex_t;

  typedef struct packed {
    logic             live;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } token_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_DONE
  } state_e;

  function automatic logic comp_near(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b,
                                     logic [TOL_W-1:0] tol);
    logic [COMP_W:0] d;
    logic [COMP_W:0] ad;
    d  = {a[COMP_W-1], a} - {b[COMP_W-1], b};
    ad = d[COMP_W] ? (~d + 1'b1) : d;
    return CMP_W'(ad) < CMP_W'(tol);
  endfunction

  function automatic logic vertex_near(vertex_t a, vertex_t b, logic [TOL_W-1:0] tol);
    return comp_near(a.pos_x, b.pos_x, tol) && comp_near(a.pos_y, b.pos_y, tol) &&
           comp_near(a.pos_z, b.pos_z, tol) && comp_near(a.col_r, b.col_r, tol) &&
           comp_near(a.col_g, b.col_g, tol) && comp_near(a.col_b, b.col_b, tol);
  endfunction

endpackage

// File: rtl/core/vdi_cell.sv
`timescale 1ns / 1ps
// One table cell: holds a stored vertex, compares it with the query and
// forwards the search token to its neighbor. Depends on vdi_pkg.
module vdi_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [vdi_pkg::IDX_W-1:0] cell_idx_i,
  input  vdi_pkg::vertex_t        query_i,
  input  logic [vdi_pkg::TOL_W-1:0] tol_i,
  input  logic [vdi_pkg::CNT_W-1:0] count_i,
  input  logic                    wr_en_i,
  input  vdi_pkg::token_t         tok_i,
  output vdi_pkg::token_t         tok_o
);

  vdi_pkg::vertex_t entry_q;
  vdi_pkg::token_t  tok_q;
  vdi_pkg::token_t  tok_d;
  logic             active;
  logic             near;

  assign active = vdi_pkg::CNT_W'(cell_idx_i) < count_i;
  assign near   = vdi_pkg::vertex_near(query_i, entry_q, tol_i);

  always_comb begin
    tok_d      = tok_i;
    if (tok_i.live && !tok_i.hit && active && near) begin
      tok_d.hit = 1'b1;
      tok_d.idx = cell_idx_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (count_i == vdi_pkg::CNT_W'(cell_idx_i))) begin
      entry_q <= query_i;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: rtl/core/vdi_chain.sv
`timescale 1ns / 1ps
// Row of table cells; the search token walks one cell per cycle.
// Depends on vdi_pkg and vdi_cell.
module vdi_chain (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  vdi_pkg::vertex_t        query_i,
  input  logic [vdi_pkg::TOL_W-1:0] tol_i,
  input  logic [vdi_pkg::CNT_W-1:0] count_i,
  input  logic                    wr_en_i,
  input  vdi_pkg::token_t         head_i,
  output vdi_pkg::token_t         tail_o
);

  vdi_pkg::token_t tok [0:vdi_pkg::TABLE_DEPTH];

  assign tok[0] = head_i;

  for (genvar g = 0; g < vdi_pkg::TABLE_DEPTH; g++) begin : g_cell
    vdi_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (vdi_pkg::IDX_W'(g)),
      .query_i    (query_i),
      .tol_i      (tol_i),
      .count_i    (count_i),
      .wr_en_i    (wr_en_i),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  assign tail_o = tok[vdi_pkg::TABLE_DEPTH];

endmodule

// File: rtl/core/vertex_dedup_indexer.sv
`timescale 1ns / 1ps
// Top level of the vertex dedup indexer: sequencer, entry count, tolerance
// register and result register around the cell row. Depends on vdi_pkg, vdi_chain.
//
//   channel | direction | handshake                 | payload
//   in      | sink      | in_valid_i / in_stall_o   | start_mesh_i, pos_*_i, col_*_i
//   out     | source    | out_valid_o / out_stall_i | vertex_index_o, is_new_o, table_full_o
//   cfg     | sink      | cfg_valid_i / cfg_ready_o | cfg_data_i (match tolerance)
//
// Each vertex is matched by the search token walking the full row of cells,
// one cell per cycle; a new vertex is taken only in the idle state.
// Reset empties the table by zeroing the entry count; no clearing pass.
// The result register lets the next vertex enter while a result waits;
// that vertex's commit waits until the output beat leaves.
module vertex_dedup_indexer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_mesh_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_x_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_y_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_z_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_r_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_g_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_b_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [vdi_pkg::VIDX_W-1:0]   vertex_index_o,
  output logic                         is_new_o,
  output logic                         table_full_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [vdi_pkg::TOL_W-1:0]    cfg_data_i
);

  vdi_pkg::state_e  state_q, state_d;
  vdi_pkg::vertex_t query_q;
  vdi_pkg::token_t  res_q, res_d;
  vdi_pkg::token_t  head;
  vdi_pkg::token_t  tail;
  logic [vdi_pkg::CNT_W-1:0]  count_q, count_d;
  logic [vdi_pkg::TOL_W-1:0]  tol_q;
  logic [vdi_pkg::VIDX_W-1:0] vidx_q, vidx_d;
  logic                       is_new_q, is_new_d;
  logic                       full_q, full_d;
  logic                       out_valid_q, out_valid_d;
  logic                       accept;
  logic                       commit;
  logic                       wr_en;
  logic                       table_at_cap;

  assign accept       = in_valid_i && !in_stall_o;
  assign table_at_cap = count_q == vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH);
  assign cfg_ready_o  = 1'b1;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    res_d       = res_q;
    vidx_d      = vidx_q;
    is_new_d    = is_new_q;
    full_d      = full_q;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    head        = '0;
    commit      = 1'b0;
    wr_en       = 1'b0;
    case (state_q)
      vdi_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (start_mesh_i) begin
            count_d = '0;
          end
          state_d = vdi_pkg::ST_LAUNCH;
        end
      end
      vdi_pkg::ST_LAUNCH: begin
        head.live = 1'b1;
        state_d   = vdi_pkg::ST_SCAN;
      end
      vdi_pkg::ST_SCAN: begin
        if (tail.live) begin
          res_d   = tail;
          state_d = vdi_pkg::ST_DONE;
        end
      end
      vdi_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          commit      = 1'b1;
          out_valid_d = 1'b1;
          state_d     = vdi_pkg::ST_IDLE;
          if (res_q.hit) begin
            vidx_d   = vdi_pkg::VIDX_W'(res_q.idx);
            is_new_d = 1'b0;
            full_d   = 1'b0;
          end else if (table_at_cap) begin
            vidx_d   = '0;
            is_new_d = 1'b0;
            full_d   = 1'b1;
          end else begin
            wr_en    = 1'b1;
            vidx_d   = vdi_pkg::VIDX_W'(vdi_pkg::IDX_W'(count_q));
            is_new_d = 1'b1;
            full_d   = 1'b0;
            count_d  = count_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = vdi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vdi_pkg::ST_IDLE;
      count_q     <= '0;
      tol_q       <= vdi_pkg::TOL_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      query_q.pos_x <= pos_x_i;
      query_q.pos_y <= pos_y_i;
      query_q.pos_z <= pos_z_i;
      query_q.col_r <= col_r_i;
      query_q.col_g <= col_g_i;
      query_q.col_b <= col_b_i;
    end
    res_q    <= res_d;
    vidx_q   <= vidx_d;
    is_new_q <= is_new_d;
    full_q   <= full_d;
  end

  vdi_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .query_i (query_q),
    .tol_i   (tol_q),
    .count_i (count_q),
    .wr_en_i (wr_en),
    .head_i  (head),
    .tail_o  (tail)
  );

  assign out_valid_o    = out_valid_q;
  assign vertex_index_o = vidx_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= vdi_pkg::CNT_W'(vdi_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_tail_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.live |-> (state_q == vdi_pkg::ST_SCAN))
    else $error("token left the row outside the scan");

  a_hit_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == vdi_pkg::ST_DONE && res_q.hit) |->
      (vdi_pkg::CNT_W'(res_q.idx) < count_q))
    else $error("hit on an unused cell");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (count_q == $past(count_q) + 1'b1) && out_valid_q && is_new_q)
    else $error("insert did not advance the count");

  a_commit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> out_valid_q && (state_q == vdi_pkg::ST_IDLE))
    else $error("commit lost its result beat");

endmodule

// File: test/vdi_lookup_checker.sv
`timescale 1ns / 1ps
// Lookup checker for the vertex dedup indexer: watches the vertex, result and
// tolerance channels, predicts each lookup and compares beats. Depends on vdi_pkg.
module vdi_lookup_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic                              start_mesh_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_x_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_y_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] pos_z_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_r_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_g_i,
  input  logic signed [vdi_pkg::COMP_W-1:0] col_b_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [vdi_pkg::VIDX_W-1:0]        vertex_index_i,
  input  logic                              is_new_i,
  input  logic                              table_full_i,
  input  logic                              cfg_valid_i,
  input  logic                              cfg_ready_i,
  input  logic [vdi_pkg::TOL_W-1:0]         cfg_data_i,
  output int                                fail_count_o,
  output int                                pending_o
);
  import vdi_pkg::*;

  typedef struct packed {
    logic [VIDX_W-1:0] index;
    logic              fresh;
    logic              full;
  } lookup_t;

  vertex_t          unique_verts [TABLE_DEPTH];
  int               vert_count;
  logic [TOL_W-1:0] tolerance_q;
  lookup_t          awaited_lookups [$];
  lookup_t          want;

  function automatic logic comp_close(logic [COMP_W-1:0] a, logic [COMP_W-1:0] b);
    longint d;
    d = longint'($signed(a)) - longint'($signed(b));
    if (d < 0) d = -d;
    return d < longint'(tolerance_q);
  endfunction

  function automatic lookup_t index_vertex(logic start, vertex_t v);
    lookup_t r;
    if (start) vert_count = 0;
    for (int i = 0; i < vert_count; i++) begin
      if (comp_close(v.pos_x, unique_verts[i].pos_x) &&
          comp_close(v.pos_y, unique_verts[i].pos_y) &&
          comp_close(v.pos_z, unique_verts[i].pos_z) &&
          comp_close(v.col_r, unique_verts[i].col_r) &&
          comp_close(v.col_g, unique_verts[i].col_g) &&
          comp_close(v.col_b, unique_verts[i].col_b)) begin
        r = '{index: VIDX_W'(i), fresh: 1'b0, full: 1'b0};
        return r;
      end
    end
    if (vert_count >= TABLE_DEPTH) begin
      r = '{index: '0, fresh: 1'b0, full: 1'b1};
      return r;
    end
    unique_verts[vert_count] = v;
    r = '{index: VIDX_W'(vert_count), fresh: 1'b1, full: 1'b0};
    vert_count++;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vert_count   = 0;
      tolerance_q  = TOL_RESET;
      awaited_lookups.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) tolerance_q = cfg_data_i;
      if (out_valid_i && !out_stall_i) begin
        if (awaited_lookups.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%t: result beat with no vertex pending: index %0d new %0b full %0b",
                     $realtime, vertex_index_i, is_new_i, table_full_i);
        end else begin
          want = awaited_lookups.pop_front();
          if (vertex_index_i !== want.index || is_new_i !== want.fresh ||
              table_full_i !== want.full) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%t: lookup mismatch: expected index %0d new %0b full %0b, got %0d %0b %0b",
                       $realtime, want.index, want.fresh, want.full,
                       vertex_index_i, is_new_i, table_full_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        awaited_lookups = {awaited_lookups, index_vertex(start_mesh_i,
            '{pos_x: pos_x_i, pos_y: pos_y_i, pos_z: pos_z_i,
              col_r: col_r_i, col_g: col_g_i, col_b: col_b_i})};
      pending_o = awaited_lookups.size();
    end
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// tb_top: vertex stream stimulus and verdict for vertex_dedup_indexer.
// Depends on vdi_pkg, the block and vdi_lookup_checker.
module tb_top;
  import vdi_pkg::*;

  localparam int     HOLD_CYCLES = 1500;
  localparam longint CYCLE_LIMIT = 1_500_000;
  localparam int     COMP_MAX    = 8388607;
  localparam int     COMP_MIN    = -8388608;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic                     start_mesh_i;
  logic signed [COMP_W-1:0] pos_x_i, pos_y_i, pos_z_i;
  logic signed [COMP_W-1:0] col_r_i, col_g_i, col_b_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic [VIDX_W-1:0]        vertex_index_o;
  logic                     is_new_o;
  logic                     table_full_o;
  logic                     cfg_valid_i;
  logic                     cfg_ready_o;
  logic [TOL_W-1:0]         cfg_data_i;
  int                       fail_count;
  int                       pending_lookups;
  logic                     quiet = 1'b0;
  logic                     hold_go = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  vertex_dedup_indexer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .start_mesh_i   (start_mesh_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .col_r_i        (col_r_i),
    .col_g_i        (col_g_i),
    .col_b_i        (col_b_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_o (vertex_index_o),
    .is_new_o       (is_new_o),
    .table_full_o   (table_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  vdi_lookup_checker lookup_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .start_mesh_i   (start_mesh_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .pos_z_i        (pos_z_i),
    .col_r_i        (col_r_i),
    .col_g_i        (col_g_i),
    .col_b_i        (col_b_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vertex_index_i (vertex_index_o),
    .is_new_i       (is_new_o),
    .table_full_i   (table_full_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .fail_count_o   (fail_count),
    .pending_o      (pending_lookups)
  );

  function automatic vertex_t make_vertex(int x, int y, int z, int r, int g, int b);
    return '{pos_x: COMP_W'(x), pos_y: COMP_W'(y), pos_z: COMP_W'(z),
             col_r: COMP_W'(r), col_g: COMP_W'(g), col_b: COMP_W'(b)};
  endfunction

  function automatic vertex_t rand_vertex();
    logic [6*COMP_W-1:0] bits;
    for (int c = 0; c < 6; c++) bits[c*COMP_W +: COMP_W] = COMP_W'($urandom);
    return vertex_t'(bits);
  endfunction

  function automatic vertex_t base_vertex();
    logic [6*COMP_W-1:0] bits;
    for (int c = 0; c < 6; c++)
      bits[c*COMP_W +: COMP_W] = COMP_W'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
    return vertex_t'(bits);
  endfunction

  function automatic vertex_t near_vertex(vertex_t base, int spread);
    logic [6*COMP_W-1:0] bits;
    int                  jit;
    bits = base;
    for (int c = 0; c < 6; c++) begin
      jit = ($urandom_range(1) == 0) ? 0 : int'($urandom_range(0, 2 * spread)) - spread;
      bits[c*COMP_W +: COMP_W] = COMP_W'(int'($signed(bits[c*COMP_W +: COMP_W])) + jit);
    end
    return vertex_t'(bits);
  endfunction

  task automatic send_vertex(input logic start, input vertex_t v);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 26) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    start_mesh_i <= start;
    pos_x_i      <= v.pos_x;
    pos_y_i      <= v.pos_y;
    pos_z_i      <= v.pos_z;
    col_r_i      <= v.col_r;
    col_g_i      <= v.col_g;
    col_b_i      <= v.col_b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_lookups();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_lookups != 0);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] tol);
    drain_lookups();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= tol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Meshes built from a small pool of base vertices with jitter around the
  // tolerance, salted with stray vertices and restarts in mid mesh.
  task automatic run_meshes(input int spread, input int target);
    vertex_t pool [$];
    int      sent;
    int      mesh_len;
    int      pick;
    sent = 0;
    while (sent < target) begin
      pool.delete();
      repeat ($urandom_range(4, 40)) pool = {pool, base_vertex()};
      mesh_len = $urandom_range(10, 60);
      for (int k = 0; k < mesh_len && sent < target; k++) begin
        pick = $urandom_range(99);
        if (pick < 8)
          send_vertex(1'b0, rand_vertex());
        else if (pick < 14)
          send_vertex(1'b1, near_vertex(pool[$urandom_range(pool.size() - 1)], spread));
        else
          send_vertex(k == 0, near_vertex(pool[$urandom_range(pool.size() - 1)], spread));
        sent++;
      end
    end
  endtask

  initial begin : rx_side
    int held;
    held        = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && held < HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        held++;
      end else if (quiet) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 26);
      end
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb_top: done, errors");
    $finish;
  end

  initial begin : stimulus
    vertex_t prev;
    int      tol;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    start_mesh_i = 1'b0;
    pos_x_i      = '0;
    pos_y_i      = '0;
    pos_z_i      = '0;
    col_r_i      = '0;
    col_g_i      = '0;
    col_b_i      = '0;
    cfg_valid_i  = 1'b0;
    cfg_data_i   = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset tolerance: boundary at 41, one component off at a time, extremes
    send_vertex(1'b1, make_vertex(0, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(0, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(40, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(41, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(-40, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(20, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(0, 41, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(0, 0, -41, 0, 0, 0));
    send_vertex(1'b0, make_vertex(0, 0, 0, 41, 0, 0));
    send_vertex(1'b0, make_vertex(0, 0, 0, 0, 41, 0));
    send_vertex(1'b0, make_vertex(0, 0, 0, 0, 0, -41));
    send_vertex(1'b0, make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_vertex(1'b0, make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_vertex(1'b0, make_vertex(COMP_MAX - 40, COMP_MAX, COMP_MAX - 1, COMP_MAX,
                                  COMP_MAX - 40, COMP_MAX));
    send_vertex(1'b0, make_vertex(COMP_MIN + 40, COMP_MIN, COMP_MIN, COMP_MIN + 7,
                                  COMP_MIN, COMP_MIN + 40));
    send_vertex(1'b0, make_vertex(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
    send_vertex(1'b1, make_vertex(5, 5, 5, 5, 5, 5));
    send_vertex(1'b0, make_vertex(0, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(46, 46, 46, 46, 46, 46));
    send_vertex(1'b0, make_vertex(-35, -35, -35, -35, -35, -35));

    // zero tolerance, no idling: fill the table and run past full
    set_tolerance('0);
    quiet = 1'b1;
    prev  = rand_vertex();
    send_vertex(1'b1, prev);
    repeat (259) begin
      if ($urandom_range(7) != 0) prev = rand_vertex();
      send_vertex(1'b0, prev);
    end
    quiet = 1'b0;

    // widest tolerance: hit a full table first, then restart
    set_tolerance({TOL_W{1'b1}});
    send_vertex(1'b0, rand_vertex());
    send_vertex(1'b0, make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_vertex(1'b0, make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_vertex(1'b1, make_vertex(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_vertex(1'b0, make_vertex(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_vertex(1'b0, make_vertex(0, 0, 0, 0, 0, 0));
    send_vertex(1'b0, make_vertex(1, 1, 1, 1, 1, 1));
    repeat (53) send_vertex($urandom_range(15) == 0, rand_vertex());

    // mesh streams at several tolerances; hold the result side off once
    for (int s = 0; s < 4; s++) begin
      case (s)
        0: tol = 1;
        1: tol = $urandom_range(2, 64);
        2: tol = $urandom_range(65, 4096);
        default: tol = $urandom_range(4097, 1 << 20);
      endcase
      set_tolerance(TOL_W'(tol));
      if (s == 1) hold_go = 1'b1;
      run_meshes(tol, 140);
    end

    drain_lookups();
    repeat (TABLE_DEPTH + 40) @(negedge clk_i);
    if (fail_count == 0 && pending_lookups == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
